[sv/pbss_pkg.sv]
// ----------------------------------------------------------------------------
// pbss_pkg - shared types and constants
// Widths of the fixed fields, register map, run and sequencer state codes.
// ----------------------------------------------------------------------------
package pbss_pkg;

	localparam int LEVEL_BITS_DEF = 16;
	localparam int COUNT_BITS_DEF = 16;

	localparam int CFG_W   = 16;    // steps_per_check, ticks_per_wave, rest_level
	localparam int CAP_W   = 24;
	localparam int AMP_W   = 15;
	localparam int HALF_W  = 15;    // half of a 16-bit even period
	localparam int QUOT_W  = 17;    // ramp quotient never exceeds amplitude + 1
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int MODE_W  = 2;

	// register indexes (paddr[4:2])
	localparam logic [2:0] REG_STEP_MODE  = 3'd0;
	localparam logic [2:0] REG_STEPS      = 3'd1;
	localparam logic [2:0] REG_TICKS      = 3'd2;
	localparam logic [2:0] REG_THRESHOLD  = 3'd3;
	localparam logic [2:0] REG_REST       = 3'd4;
	localparam logic [2:0] REG_UP_AMP     = 3'd5;
	localparam logic [2:0] REG_DOWN_AMP   = 3'd6;

	// step modes; bit 1 set means finish on the capacitance threshold
	localparam logic [MODE_W-1:0] MODE_UP   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DOWN = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CAP  = 2'd2;

	localparam logic [0:0] OP_TICK  = 1'b0;
	localparam logic [0:0] OP_START = 1'b1;

	typedef enum logic [1:0] {
		RS_IDLE    = 2'd0,
		RS_MEASURE = 2'd1,
		RS_STEP    = 2'd2,
		RS_DONE    = 2'd3
	} run_state_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_CALC,
		SQ_HOLD
	} seq_state_t;

endpackage

[sv/pbss_if.sv]
// ----------------------------------------------------------------------------
// pbss_if - request and result channels
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pbss_in_if;
	logic                        valid;
	logic                        ready;
	logic                        op;
	logic                        tracker_done;
	logic [pbss_pkg::CAP_W-1:0]  capacitance;

	modport source (output valid, op, tracker_done, capacitance, input ready);
	modport sink   (input valid, op, tracker_done, capacitance, output ready);
endinterface

interface pbss_out_if #(
	parameter int LEVEL_BITS = pbss_pkg::LEVEL_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [LEVEL_BITS-1:0]  drive_level;
	logic                          bias_zero;
	logic                          measure_request;
	logic [1:0]                    run_state;

	modport source (output valid, drive_level, bias_zero, measure_request, run_state,
		input ready);
	modport sink   (input valid, drive_level, bias_zero, measure_request, run_state,
		output ready);
endinterface

[sv/piezo_blind_step_sequencer.sv]
// ----------------------------------------------------------------------------
// piezo_blind_step_sequencer - blind step sequencer for a piezo positioner
// Start/tick requests in, one drive result per request out; APB registers.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake      | payload
//  ----------+-----+----------------+------------------------------------------
//  in_req    | in  | valid/ready    | op, tracker_done, capacitance[23:0]
//  out_res   | out | valid/ready    | drive_level, bias_zero, measure_request,
//            |     |                | run_state
//  apb       | in  | psel/penable   | paddr[4:0], pwdata/prdata[31:0], pready=1
//
//  A request goes to its result thus: the multiply settles in the accept cycle,
//  the ramp unit then divides one quotient bit at a time, its done flag hands
//  the quotient to the sequencer and the sequencer loads the result register.
//  in_req.ready is high only while the sequencer is idle; it comes back with
//  the result, so a new request is only taken once the last result is loaded.
//  A result held in the output register while out_res.ready is low holds the
//  next computed result in the ramp unit; the next request waits for both.
//  arst_n clears run state, counters and the sequencer and sets the config registers to their defaults.
//
module piezo_blind_step_sequencer #(
	parameter int LEVEL_BITS = pbss_pkg::LEVEL_BITS_DEF,
	parameter int COUNT_BITS = pbss_pkg::COUNT_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	pbss_in_if.sink                      in_req,
	pbss_out_if.source                   out_res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pbss_pkg::ADDR_W-1:0]  paddr,
	input  logic [pbss_pkg::DATA_W-1:0]  pwdata,
	output logic [pbss_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import pbss_pkg::*;

	localparam int CMP_W = ((COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W) + 1;
	localparam int SUM_W = CFG_W + 3;
	localparam int SAT_W = ((LEVEL_BITS > SUM_W) ? LEVEL_BITS : SUM_W) + 1;
	localparam logic signed [SAT_W-1:0] LVL_MAX =
		SAT_W'((longint'(1) << (LEVEL_BITS - 1)) - 1);
	localparam logic signed [SAT_W-1:0] LVL_MIN = -LVL_MAX - SAT_W'(1);

	// ---------------------------------------------------------------- config
	logic [MODE_W-1:0]      step_mode_q;
	logic [CFG_W-1:0]       steps_q;
	logic [CFG_W-1:0]       ticks_q;
	logic [CAP_W-1:0]       threshold_q;
	logic signed [CFG_W-1:0] rest_q;
	logic [AMP_W-1:0]       up_amp_q;
	logic [AMP_W-1:0]       down_amp_q;

	logic       cfg_wr;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_mode_q <= MODE_UP;
			steps_q     <= CFG_W'(1);
			ticks_q     <= CFG_W'(2);
			threshold_q <= '0;
			rest_q      <= '0;
			up_amp_q    <= '0;
			down_amp_q  <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_STEP_MODE: step_mode_q <= pwdata[MODE_W-1:0];
				REG_STEPS:     steps_q     <= pwdata[CFG_W-1:0];
				REG_TICKS:     ticks_q     <= pwdata[CFG_W-1:0];
				REG_THRESHOLD: threshold_q <= pwdata[CAP_W-1:0];
				REG_REST:      rest_q      <= pwdata[CFG_W-1:0];
				REG_UP_AMP:    up_amp_q    <= pwdata[AMP_W-1:0];
				REG_DOWN_AMP:  down_amp_q  <= pwdata[AMP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_STEP_MODE: prdata = DATA_W'(step_mode_q);
			REG_STEPS:     prdata = DATA_W'(steps_q);
			REG_TICKS:     prdata = DATA_W'(ticks_q);
			REG_THRESHOLD: prdata = DATA_W'(threshold_q);
			REG_REST:      prdata = DATA_W'($unsigned(rest_q));
			REG_UP_AMP:    prdata = DATA_W'(up_amp_q);
			REG_DOWN_AMP:  prdata = DATA_W'(down_amp_q);
			default:       prdata = '0;
		endcase
	end

	// wave period: even, at least 2; half period drives the ramp slope
	logic [CFG_W-1:0]  period;
	logic [HALF_W-1:0] half;
	logic [CFG_W-1:0]  period_raw;

	assign period_raw = {ticks_q[CFG_W-1:1], 1'b0};
	assign period     = (period_raw < CFG_W'(2)) ? CFG_W'(2) : period_raw;
	assign half       = period[CFG_W-1:1];

	// ---------------------------------------------------------------- run state
	run_state_t             run_q;
	logic                   stepped_q;
	logic [COUNT_BITS-1:0]  phase_q;
	logic [COUNT_BITS-1:0]  waves_q;

	seq_state_t seq_q, seq_d;
	logic       in_fire;
	logic       load_out;

	assign in_fire = in_req.valid && in_req.ready;

	// next-tick evaluation, all from the current state and the request
	run_state_t             t_run;
	logic                   t_stepped;
	logic [COUNT_BITS-1:0]  t_phase;
	logic [COUNT_BITS-1:0]  t_waves;
	logic                   t_req;
	logic                   t_step;
	logic                   t_finish;
	logic [COUNT_BITS-1:0]  cur_phase;
	logic [COUNT_BITS-1:0]  cur_waves;
	logic [COUNT_BITS:0]    phase_inc;
	logic                   wrap;
	logic                   mode_down;
	logic [COUNT_BITS-1:0]  r_x;
	logic [AMP_W-1:0]       r_amp;
	logic [AMP_W-1:0]       r_base;
	logic                   r_neg;

	assign mode_down = (step_mode_q == MODE_DOWN);

	always_comb begin
		t_run     = run_q;
		t_stepped = stepped_q;
		cur_phase = phase_q;
		cur_waves = waves_q;
		t_req     = 1'b0;
		t_finish  = 1'b0;
		if (in_req.op == OP_START) begin
			t_run     = RS_MEASURE;
			t_stepped = 1'b0;
			cur_phase = '0;
			cur_waves = '0;
		end else begin
			// burst over: measure again
			if (t_run == RS_STEP && CMP_W'(waves_q) >= CMP_W'(steps_q)) begin
				t_run     = RS_MEASURE;
				t_stepped = 1'b1;
			end
			if (t_run == RS_MEASURE) begin
				t_req = 1'b1;
				if (in_req.tracker_done) begin
					t_finish  = step_mode_q[1] ? (in_req.capacitance > threshold_q)
						: t_stepped;
					t_run     = t_finish ? RS_DONE : RS_STEP;
					cur_phase = '0;
					cur_waves = '0;
				end
			end
		end
		t_step = (in_req.op == OP_TICK) && (t_run == RS_STEP);

		phase_inc = {1'b0, cur_phase} + 1'b1;
		wrap      = (CMP_W'(phase_inc) >= CMP_W'(period)) || phase_inc[COUNT_BITS];
		t_phase   = cur_phase;
		t_waves   = cur_waves;
		if (t_step) begin
			if (wrap) begin
				t_phase = '0;
				if (cur_waves != '1) begin
					t_waves = cur_waves + 1'b1;
				end
			end else begin
				t_phase = phase_inc[COUNT_BITS-1:0];
			end
		end

		// ramp operands; x = 0 gives a zero quotient on the flat parts
		r_x    = '0;
		r_amp  = '0;
		r_base = '0;
		r_neg  = 1'b0;
		if (t_step) begin
			if (mode_down) begin
				r_base = down_amp_q;
				r_neg  = 1'b1;
				if (CMP_W'(cur_phase) >= CMP_W'(half)) begin
					r_x   = COUNT_BITS'(CMP_W'(cur_phase) - CMP_W'(half));
					r_amp = down_amp_q;
				end
			end else if (CMP_W'(cur_phase) <= CMP_W'(half)) begin
				r_x   = cur_phase;
				r_amp = up_amp_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q     <= RS_IDLE;
			stepped_q <= 1'b0;
			phase_q   <= '0;
			waves_q   <= '0;
		end else if (in_fire) begin
			run_q     <= t_run;
			stepped_q <= t_stepped;
			phase_q   <= t_phase;
			waves_q   <= t_waves;
		end
	end

	// per-request fields waiting for the ramp quotient
	logic             item_bias_q;
	logic             item_req_q;
	run_state_t       item_run_q;
	logic [AMP_W-1:0] item_base_q;
	logic             item_neg_q;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_bias_q <= t_step;
			item_req_q  <= t_req;
			item_run_q  <= t_run;
			item_base_q <= r_base;
			item_neg_q  <= r_neg;
		end
	end

	// ---------------------------------------------------------------- ramp unit
	logic              ramp_done;
	logic [QUOT_W-1:0] ramp_quot;

	pbss_ramp_unit #(
		.COUNT_BITS(COUNT_BITS)
	) u_ramp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_fire),
		.x      (r_x),
		.amp    (r_amp),
		.half   (half),
		.done   (ramp_done),
		.quot   (ramp_quot)
	);

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SQ_IDLE;
		end else begin
			seq_q <= seq_d;
		end
	end

	always_comb begin
		seq_d        = seq_q;
		in_req.ready = 1'b0;
		load_out     = 1'b0;
		unique case (seq_q)
			SQ_IDLE: begin
				in_req.ready = 1'b1;
				if (in_req.valid) begin
					seq_d = SQ_CALC;
				end
			end
			SQ_CALC: begin
				if (ramp_done) begin
					seq_d = SQ_HOLD;
				end
			end
			SQ_HOLD: begin
				if (!out_res.valid || out_res.ready) begin
					load_out = 1'b1;
					seq_d    = SQ_IDLE;
				end
			end
			default: seq_d = SQ_IDLE;
		endcase
	end

	// ---------------------------------------------------------------- level
	// rest + base -/+ quotient, then clamp to LEVEL_BITS signed
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  quot_s;
	logic signed [SAT_W-1:0]  sum_ext;
	logic [LEVEL_BITS-1:0]    level;

	assign quot_s  = $signed({{(SUM_W-QUOT_W){1'b0}}, ramp_quot});
	assign sum     = SUM_W'(rest_q) + $signed({{(SUM_W-AMP_W){1'b0}}, item_base_q})
		+ (item_neg_q ? -quot_s : quot_s);
	assign sum_ext = SAT_W'(sum);

	always_comb begin
		if (sum_ext > LVL_MAX) begin
			level = LVL_MAX[LEVEL_BITS-1:0];
		end else if (sum_ext < LVL_MIN) begin
			level = LVL_MIN[LEVEL_BITS-1:0];
		end else begin
			level = sum_ext[LEVEL_BITS-1:0];
		end
	end

	// ---------------------------------------------------------------- result register
	logic                  out_valid_q;
	logic [LEVEL_BITS-1:0] out_level_q;
	logic                  out_bias_q;
	logic                  out_req_q;
	logic [1:0]            out_run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_level_q <= level;
			out_bias_q  <= item_bias_q;
			out_req_q   <= item_req_q;
			out_run_q   <= item_run_q;
		end
	end

	assign out_res.valid           = out_valid_q;
	assign out_res.drive_level     = $signed(out_level_q);
	assign out_res.bias_zero       = out_bias_q;
	assign out_res.measure_request = out_req_q;
	assign out_res.run_state       = out_run_q;

`ifndef SYNTHESIS
	// one request at a time: ready drops right after an accept
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_req.ready)
		else $error("request accepted while a previous one is in flight");

	// a stepping tick always leaves the run in the stepping state
	a_bias_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_res.valid && out_res.bias_zero |-> out_res.run_state == RS_STEP)
		else $error("bias forced to zero outside stepping");

	// a measure request never reports an idle run
	a_req_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_res.valid && out_res.measure_request |-> out_res.run_state != RS_IDLE)
		else $error("measurement requested while idle");

	// the ramp unit only finishes while the sequencer waits for it
	a_done_calc: assert property (@(posedge clk) disable iff (!arst_n)
		ramp_done |-> seq_q == SQ_CALC)
		else $error("ramp result outside calculation");
`endif

endmodule

[sv/pbss_ramp_unit.sv]
// ----------------------------------------------------------------------------
// pbss_ramp_unit - ramp sample arithmetic
// One multiply, then a restoring divide one quotient bit per cycle:
// quot = (x * amp + half/2) / half.
// ----------------------------------------------------------------------------
module pbss_ramp_unit #(
	parameter int COUNT_BITS = pbss_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [COUNT_BITS-1:0]         x,
	input  logic [pbss_pkg::AMP_W-1:0]    amp,
	input  logic [pbss_pkg::HALF_W-1:0]   half,
	output logic                          done,
	output logic [pbss_pkg::QUOT_W-1:0]   quot
);
	import pbss_pkg::*;

	localparam int NUM_W = COUNT_BITS + AMP_W + 1;
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0]  num_q;
	logic [HALF_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;

	logic [NUM_W-1:0]  prod;
	logic [HALF_W:0]   rem_sh;
	logic [HALF_W:0]   rem_sub;
	logic              ge;

	assign prod = {{(NUM_W-COUNT_BITS){1'b0}}, x} * {{(NUM_W-AMP_W){1'b0}}, amp};
	assign rem_sh  = {rem_q, num_q[NUM_W-1]};
	assign ge      = rem_sh >= {1'b0, half};
	assign rem_sub = rem_sh - {1'b0, half};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out the top while quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= prod + NUM_W'(half >> 1);
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? rem_sub[HALF_W-1:0] : rem_sh[HALF_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q[QUOT_W-1:0];

endmodule
